@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk outside reset.
`define SBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define SBT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/sbt_pkg.sv @@
package sbt_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int LENGTH_BITS_DEFAULT   = 16;
  localparam int QUEUE_DEPTH           = 4;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
  } byte_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] text_length;
    logic [7:0]  char_value;
    logic        last;
  } token_t;

  typedef enum logic [3:0] {
    M_IDLE       = 4'd0,
    M_WORD       = 4'd1,
    M_NUMBER     = 4'd2,
    M_MINUS      = 4'd3,
    M_CHAR_OPEN  = 4'd4,
    M_CHAR_ESC   = 4'd5,
    M_CHAR_CLOSE = 4'd6,
    M_STRING     = 4'd7,
    M_HALT       = 4'd8
  } mode_t;

  localparam logic [4:0] KIND_IDENT      = 5'd11;
  localparam logic [4:0] KIND_NUMBER     = 5'd12;
  localparam logic [4:0] KIND_CHAR       = 5'd13;
  localparam logic [4:0] KIND_ARROW      = 5'd14;
  localparam logic [4:0] KIND_MINUS      = 5'd15;
  localparam logic [4:0] KIND_COLON      = 5'd16;
  localparam logic [4:0] KIND_ASSIGN     = 5'd17;
  localparam logic [4:0] KIND_PLUS       = 5'd18;
  localparam logic [4:0] KIND_STAR       = 5'd19;
  localparam logic [4:0] KIND_SLASH      = 5'd20;
  localparam logic [4:0] KIND_LPAREN     = 5'd21;
  localparam logic [4:0] KIND_RPAREN     = 5'd22;
  localparam logic [4:0] KIND_LBRACE     = 5'd23;
  localparam logic [4:0] KIND_RBRACE     = 5'd24;
  localparam logic [4:0] KIND_STRING     = 5'd25;
  localparam logic [4:0] KIND_UNKNOWN    = 5'd26;
  localparam logic [4:0] KIND_END        = 5'd27;
  localparam logic [4:0] KIND_CHAR_ERROR = 5'd28;

  localparam int KEYWORD_COUNT = 11;

  // Keyword text with byte i in bits 8i+7:8i; unused upper bytes are zero.
  localparam logic [47:0] KEYWORD_TEXT [KEYWORD_COUNT] = '{
    48'h0000_636E_7566,
    48'h0074_7261_7473,
    48'h0074_6E69_7270,
    48'h0074_736E_6F63,
    48'h0038_7261_6863,
    48'h3631_7261_6863,
    48'h3233_7261_6863,
    48'h0000_3874_6E69,
    48'h0036_3174_6E69,
    48'h0032_3374_6E69,
    48'h0034_3674_6E69
  };

  // Word bytes are never zero, so a whole-word match on a word of at most
  // six bytes also matches its length.
  function automatic logic [4:0] word_kind(input logic [47:0] word, input logic short_word);
    logic [4:0] k;
    k = KIND_IDENT;
    for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
      if (short_word && word == KEYWORD_TEXT[i]) begin
        k = 5'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [4:0] op_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h3A:   k = KIND_COLON;
      8'h3D:   k = KIND_ASSIGN;
      8'h2B:   k = KIND_PLUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

@@ hdl/sbt_lexer.sv @@
`include "assert_macros.svh"

module sbt_lexer #(
  parameter int POSITION_BITS = sbt_pkg::POSITION_BITS_DEFAULT,
  parameter int LENGTH_BITS   = sbt_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  sbt_pkg::byte_item_t item,
  output sbt_pkg::token_t    tok0,
  output sbt_pkg::token_t    tok1,
  output logic [1:0]         tok_count
);

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;

  sbt_pkg::mode_t           mode, mode_next;
  logic [47:0]              word_bytes, word_bytes_next;
  logic [LENGTH_BITS-1:0]   token_length, token_length_next;
  logic [POSITION_BITS-1:0] token_line, token_line_next;
  logic [POSITION_BITS-1:0] token_column, token_column_next;
  logic [POSITION_BITS-1:0] line_count, line_count_next;
  logic [POSITION_BITS-1:0] column_count, column_count_next;
  logic [7:0]               literal_byte, literal_byte_next;

  function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] pos_out(input logic [POSITION_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [15:0] len_out(input logic [LENGTH_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  logic [7:0]  c;
  logic        short_word;
  logic [4:0]  cur_word_kind;
  logic [15:0] tok_line_out, tok_col_out, tok_len_out;

  assign c             = item.ch;
  assign short_word    = 32'(token_length) <= 32'd6;
  assign cur_word_kind = sbt_pkg::word_kind(word_bytes, short_word);
  assign tok_line_out  = pos_out(token_line);
  assign tok_col_out   = pos_out(token_column);
  assign tok_len_out   = len_out(token_length);

  sbt_pkg::token_t t_a, t_b;
  logic            v_a, v_b;

  always_comb begin
    logic adv;
    logic idle;
    logic start_tok;
    logic [POSITION_BITS-1:0] col_end;
    mode_next         = mode;
    word_bytes_next   = word_bytes;
    token_length_next = token_length;
    token_line_next   = token_line;
    token_column_next = token_column;
    line_count_next   = line_count;
    column_count_next = column_count;
    literal_byte_next = literal_byte;
    t_a       = '0;
    t_b       = '0;
    v_a       = 1'b0;
    v_b       = 1'b0;
    adv       = 1'b0;
    idle      = 1'b0;
    start_tok = 1'b0;
    t_a.start_line   = tok_line_out;
    t_a.start_column = tok_col_out;
    t_a.text_length  = tok_len_out;
    t_b.start_line   = pos_out(line_count);
    t_b.start_column = pos_out(column_count);
    col_end = (mode == sbt_pkg::M_STRING) ? pos_inc(column_count) : column_count;
    if (fire) begin
      if (item.kind) begin
        case (mode)
          sbt_pkg::M_WORD: begin
            v_a = 1'b1;
            t_a.token_kind = cur_word_kind;
          end
          sbt_pkg::M_NUMBER: begin
            v_a = 1'b1;
            t_a.token_kind = sbt_pkg::KIND_NUMBER;
          end
          sbt_pkg::M_MINUS: begin
            v_a = 1'b1;
            t_a.token_kind  = sbt_pkg::KIND_MINUS;
            t_a.text_length = 16'd1;
          end
          sbt_pkg::M_STRING: begin
            v_a = 1'b1;
            t_a.token_kind = sbt_pkg::KIND_STRING;
          end
          sbt_pkg::M_CHAR_OPEN, sbt_pkg::M_CHAR_ESC, sbt_pkg::M_CHAR_CLOSE: begin
            v_a = 1'b1;
            t_a.token_kind  = sbt_pkg::KIND_CHAR_ERROR;
            t_a.text_length = 16'd0;
          end
          default: begin
            v_a = 1'b0;
          end
        endcase
        v_b = 1'b1;
        t_b.token_kind   = sbt_pkg::KIND_END;
        t_b.start_column = pos_out(col_end);
        t_b.text_length  = 16'd0;
        mode_next         = sbt_pkg::M_IDLE;
        word_bytes_next   = '0;
        token_length_next = '0;
        token_line_next   = POSITION_BITS'(1);
        token_column_next = POSITION_BITS'(1);
        line_count_next   = POSITION_BITS'(1);
        column_count_next = POSITION_BITS'(1);
        literal_byte_next = '0;
      end else begin
        case (mode)
          sbt_pkg::M_HALT: begin
            adv = 1'b0;
          end
          sbt_pkg::M_WORD: begin
            if (sbt_pkg::is_alpha(c) || sbt_pkg::is_digit(c)) begin
              for (int i = 0; i < 6; i++) begin
                if (token_length == LENGTH_BITS'(i)) begin
                  word_bytes_next[8*i +: 8] = c;
                end
              end
              token_length_next = len_inc(token_length);
              adv = 1'b1;
            end else begin
              v_a = 1'b1;
              t_a.token_kind = cur_word_kind;
              idle = 1'b1;
            end
          end
          sbt_pkg::M_NUMBER: begin
            if (sbt_pkg::is_digit(c)) begin
              token_length_next = len_inc(token_length);
              adv = 1'b1;
            end else begin
              v_a = 1'b1;
              t_a.token_kind = sbt_pkg::KIND_NUMBER;
              idle = 1'b1;
            end
          end
          sbt_pkg::M_MINUS: begin
            v_a = 1'b1;
            if (c == CH_GREATER) begin
              t_a.token_kind  = sbt_pkg::KIND_ARROW;
              t_a.text_length = 16'd2;
              adv = 1'b1;
              mode_next = sbt_pkg::M_IDLE;
            end else begin
              t_a.token_kind  = sbt_pkg::KIND_MINUS;
              t_a.text_length = 16'd1;
              idle = 1'b1;
            end
          end
          sbt_pkg::M_CHAR_OPEN: begin
            if (c == CH_BSLASH) begin
              mode_next = sbt_pkg::M_CHAR_ESC;
            end else begin
              literal_byte_next = c;
              mode_next = sbt_pkg::M_CHAR_CLOSE;
            end
            adv = 1'b1;
          end
          sbt_pkg::M_CHAR_ESC: begin
            literal_byte_next = c;
            mode_next = sbt_pkg::M_CHAR_CLOSE;
            adv = 1'b1;
          end
          sbt_pkg::M_CHAR_CLOSE: begin
            v_a = 1'b1;
            if (c == CH_QUOTE) begin
              t_a.token_kind  = sbt_pkg::KIND_CHAR;
              t_a.text_length = 16'd1;
              t_a.char_value  = literal_byte;
              adv = 1'b1;
              mode_next = sbt_pkg::M_IDLE;
            end else begin
              t_a.token_kind  = sbt_pkg::KIND_CHAR_ERROR;
              t_a.text_length = 16'd0;
              mode_next = sbt_pkg::M_HALT;
            end
          end
          sbt_pkg::M_STRING: begin
            adv = 1'b1;
            if (c == CH_DQUOTE || c == 8'h00) begin
              v_a = 1'b1;
              t_a.token_kind = sbt_pkg::KIND_STRING;
              mode_next = sbt_pkg::M_IDLE;
            end else begin
              token_length_next = len_inc(token_length);
            end
          end
          default: begin
            idle = 1'b1;
          end
        endcase
        if (idle) begin
          mode_next = sbt_pkg::M_IDLE;
          adv = 1'b1;
          if (sbt_pkg::is_space(c)) begin
            mode_next = sbt_pkg::M_IDLE;
          end else if (sbt_pkg::is_alpha(c)) begin
            start_tok = 1'b1;
            mode_next = sbt_pkg::M_WORD;
          end else if (sbt_pkg::is_digit(c)) begin
            start_tok = 1'b1;
            mode_next = sbt_pkg::M_NUMBER;
          end else if (c == CH_QUOTE) begin
            start_tok = 1'b1;
            mode_next = sbt_pkg::M_CHAR_OPEN;
          end else if (c == CH_MINUS) begin
            start_tok = 1'b1;
            mode_next = sbt_pkg::M_MINUS;
          end else if (c == CH_DQUOTE) begin
            start_tok = 1'b1;
            mode_next = sbt_pkg::M_STRING;
          end else begin
            v_b = 1'b1;
            t_b.token_kind  = sbt_pkg::op_kind(c);
            t_b.text_length = 16'd1;
          end
          if (start_tok) begin
            token_line_next   = line_count;
            token_column_next = column_count;
            literal_byte_next = '0;
            if (sbt_pkg::is_alpha(c)) begin
              word_bytes_next   = {40'd0, c};
              token_length_next = LENGTH_BITS'(1);
            end else if (sbt_pkg::is_digit(c)) begin
              word_bytes_next   = '0;
              token_length_next = LENGTH_BITS'(1);
            end else begin
              word_bytes_next   = '0;
              token_length_next = '0;
            end
          end
        end
        if (adv) begin
          if (c == CH_NEWLINE) begin
            line_count_next   = pos_inc(line_count);
            column_count_next = POSITION_BITS'(1);
          end else begin
            column_count_next = pos_inc(column_count);
          end
        end
      end
    end
  end

  always_comb begin
    tok0 = v_a ? t_a : t_b;
    tok1 = t_b;
    tok0.last = !(v_a && v_b);
    tok1.last = 1'b1;
    tok_count = 2'(v_a) + 2'(v_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= sbt_pkg::M_IDLE;
      word_bytes   <= '0;
      token_length <= '0;
      token_line   <= POSITION_BITS'(1);
      token_column <= POSITION_BITS'(1);
      line_count   <= POSITION_BITS'(1);
      column_count <= POSITION_BITS'(1);
      literal_byte <= '0;
    end else begin
      mode         <= mode_next;
      word_bytes   <= word_bytes_next;
      token_length <= token_length_next;
      token_line   <= token_line_next;
      token_column <= token_column_next;
      line_count   <= line_count_next;
      column_count <= column_count_next;
      literal_byte <= literal_byte_next;
    end
  end

  `SBT_ASSERT(a_tokens_need_item, (tok_count != 2'd0) |-> fire, "token without a transaction")
  `SBT_ASSERT(a_end_restarts, (fire && item.kind) |=> (mode == sbt_pkg::M_IDLE && line_count == POSITION_BITS'(1) && column_count == POSITION_BITS'(1)), "end of source did not restart the lexer")
  `SBT_ASSERT(a_halt_holds, (mode == sbt_pkg::M_HALT && !(fire && item.kind)) |=> (mode == sbt_pkg::M_HALT && $stable(line_count) && $stable(column_count)), "halted lexer moved")

endmodule

@@ hdl/sbt_token_queue.sv @@
`include "assert_macros.svh"

module sbt_token_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_count,
  input  sbt_pkg::token_t push0,
  input  sbt_pkg::token_t push1,
  output logic            room,
  output logic            token_valid,
  input  logic            token_ready,
  output sbt_pkg::token_t token_data
);

  localparam int DEPTH = sbt_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  sbt_pkg::token_t entry [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count, count_next;
  logic            pop;

  assign room        = count <= CW'(DEPTH - 2);
  assign token_valid = count != '0;
  assign token_data  = entry[rd_ptr];
  assign pop         = token_valid && token_ready;
  assign count_next  = count + CW'(push_count) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entry[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entry[wr_ptr + PW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_count);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count_next;
    end
  end

  `SBT_ASSERT_ALWAYS(a_count_bound, rst || count <= CW'(DEPTH), "token queue overfilled")
  `SBT_ASSERT(a_push_fits, (push_count != 2'd0) |-> room, "tokens pushed without room")
  `SBT_ASSERT(a_pop_only, (pop && push_count == 2'd0) |=> (count == $past(count) - CW'(1)), "queue count did not follow a lone pop")

endmodule

@@ hdl/source_byte_tokenizer.sv @@
// Streaming lexer: one source byte or end-of-source mark per byte transaction, one token per
// token transaction. A byte transaction can be taken in every cycle while the token queue has
// room; the byte is held in the input register, is lexed in one pass, and its tokens enter a
// four-entry token queue that drains one token per cycle while token_ready is high.
// Sustained rate is one byte per cycle while bytes give at most one token each and tokens are
// taken; a byte that closes a word, number or minus and is itself a token gives two, and the
// single queue read port then sets the pace at one token per cycle.
module source_byte_tokenizer #(
  parameter int POSITION_BITS = sbt_pkg::POSITION_BITS_DEFAULT,
  parameter int LENGTH_BITS   = sbt_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  sbt_pkg::byte_item_t byte_data,
  output logic                token_valid,
  input  logic                token_ready,
  output sbt_pkg::token_t     token_data
);

  logic                held_valid;
  sbt_pkg::byte_item_t held_item;
  logic                room;
  logic                fire;
  sbt_pkg::token_t     tok0, tok1;
  logic [1:0]          tok_count;

  assign fire       = held_valid && room;
  assign byte_ready = !held_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (byte_ready) begin
      held_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      held_item <= byte_data;
    end
  end

  sbt_lexer #(
    .POSITION_BITS(POSITION_BITS),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_lexer (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (held_item),
    .tok0     (tok0),
    .tok1     (tok1),
    .tok_count(tok_count)
  );

  sbt_token_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (tok_count),
    .push0      (tok0),
    .push1      (tok1),
    .room       (room),
    .token_valid(token_valid),
    .token_ready(token_ready),
    .token_data (token_data)
  );

endmodule
